FILE: hw/rtl/pbfl_pkg.sv
// Shared types and constants for the page block free-list allocator.
// No dependencies; imported by pbfl_free_eval and page_block_free_list_allocator_top.
package pbfl_pkg;

	localparam int IDX_W = 6;   // block index field width
	localparam int CNT_W = 7;   // count and config field width

	localparam logic [CNT_W-1:0] RESULT_CAP  = 7'd64;
	localparam logic [CNT_W-1:0] OUT_LIMIT   = 7'd127;
	localparam logic [CNT_W-1:0] CFG_RESET   = 7'd64;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_CFREE = 2'd2,
		REQ_UFREE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		FST_OK        = 2'd0,
		FST_WAS_EMPTY = 2'd1,
		FST_LAST      = 2'd2,
		FST_ERROR     = 2'd3
	} free_status_t;

	typedef struct packed {
		logic uncond;
		logic bad_index;
		logic was_empty;
		logic out_zero;
		logic out_one;
	} free_req_t;

	typedef struct packed {
		logic         push;
		free_status_t status;
	} free_dec_t;

endpackage

FILE: hw/rtl/pbfl_link_ram.sv
// Link table of the free list: one write port, one registered read port.
// No dependencies.
module pbfl_link_ram #(
	parameter int DEPTH = 64,
	parameter int DW    = 7,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/pbfl_free_eval.sv
// Free request decision: whether to push the block and which status to report.
// Depends on pbfl_pkg.
module pbfl_free_eval (
	input  pbfl_pkg::free_req_t req,
	output pbfl_pkg::free_dec_t dec
);
	import pbfl_pkg::*;

	always_comb begin
		dec.push   = 1'b0;
		dec.status = FST_OK;
		if (req.bad_index || req.out_zero) begin
			dec.status = FST_ERROR;
		end else if (!req.uncond && req.out_one) begin
			dec.status = FST_LAST;
		end else if (!req.uncond && req.was_empty) begin
			dec.status = FST_WAS_EMPTY;
		end else begin
			dec.push = 1'b1;
			if (!req.uncond) begin
				dec.status = FST_OK;
			end else if (req.out_one) begin
				// counter reaches zero: page wholly free
				dec.status = FST_LAST;
			end else if (req.was_empty) begin
				dec.status = FST_WAS_EMPTY;
			end else begin
				dec.status = FST_OK;
			end
		end
	end

endmodule

FILE: hw/rtl/page_block_free_list_allocator_top.sv
// Free-list block allocator for one page: control sequencer and link table.
// Depends on pbfl_pkg, pbfl_link_ram and pbfl_free_eval.
//
// Requests are taken when start is high and busy is low. A free gives its one
// result beat the cycle after it is taken and leaves busy low, so frees can
// follow each other every cycle. Init writes one link per cycle for each of
// blocks_in_page blocks (clamped to 1..MAX_BLOCKS) and gives its beat in the
// cycle after the last write. Allocate walks the list through the registered
// link table read: a write-back state gives out each block, with a read state
// between blocks for the next link; a zero grant gives a single beat in the
// cycle after the request. Result beats are strobed for one cycle and cannot be
// held off by the receiver; the final beat of each request carries last.
module page_block_free_list_allocator_top #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] blocks_in_page,
	input  logic       start,
	input  logic [1:0] req_type,
	input  logic [6:0] req_count,
	input  logic [5:0] block_index,
	output logic       busy,
	output logic       result_strobe,
	output logic [5:0] alloc_block,
	output logic       block_valid,
	output logic [6:0] alloc_count,
	output logic       now_empty,
	output logic [1:0] free_status,
	output logic       last
);
	import pbfl_pkg::*;

	localparam int LW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = (LW > IDX_W) ? LW : IDX_W;
	localparam int EW = (LW > CNT_W) ? LW : CNT_W;
	localparam logic [LW-1:0] LIST_END = LW'(MAX_BLOCKS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_ALLOC_RD,
		ST_ALLOC_WB
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cfg_q;
	logic [LW-1:0]    head_q;
	logic [CNT_W-1:0] out_q;
	logic [LW-1:0]    init_q;
	logic [CNT_W-1:0] want_q;
	logic [CNT_W-1:0] got_q;

	logic             strobe_q;
	logic [IDX_W-1:0] blk_q;
	logic             valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic             empty_q;
	free_status_t     status_q;
	logic             last_q;

	logic [LW-1:0]    n_eff;
	logic             accept;
	req_type_t        rtype;
	logic [CNT_W-1:0] want_c;
	logic             head_empty;
	logic [LW-1:0]    init_nxt;
	logic [LW-1:0]    init_link;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [LW-1:0]    ram_wdata;
	logic [LW-1:0]    ram_rdata;

	logic [CNT_W-1:0] got_n;
	logic             walk_end;
	logic             nh_empty;
	logic [CNT_W:0]   out_sum;

	free_req_t        frq;
	free_dec_t        fdec;

	always_comb begin
		if (cfg_q == '0) begin
			n_eff = LW'(1);
		end else if (EW'(cfg_q) > EW'(MAX_BLOCKS)) begin
			n_eff = LIST_END;
		end else begin
			n_eff = LW'(cfg_q);
		end
	end

	assign accept     = start && (state_q == ST_IDLE);
	assign rtype      = req_type_t'(req_type);
	assign want_c     = (req_count > RESULT_CAP) ? RESULT_CAP : req_count;
	assign head_empty = (head_q >= LIST_END);
	assign init_nxt   = init_q + LW'(1);
	assign init_link  = (init_nxt < n_eff) ? init_nxt : LIST_END;

	assign frq.uncond    = (rtype == REQ_UFREE);
	assign frq.bad_index = (CW'(block_index) >= CW'(n_eff));
	assign frq.was_empty = head_empty;
	assign frq.out_zero  = (out_q == '0);
	assign frq.out_one   = (out_q == CNT_W'(1));

	pbfl_free_eval u_free_eval (
		.req (frq),
		.dec (fdec)
	);

	wire free_req = (rtype == REQ_CFREE) || (rtype == REQ_UFREE);

	always_comb begin
		if (state_q == ST_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = init_q[AW-1:0];
			ram_wdata = init_link;
		end else begin
			ram_we    = accept && free_req && fdec.push;
			ram_waddr = AW'(block_index);
			ram_wdata = head_q;
		end
	end

	pbfl_link_ram #(
		.DEPTH (MAX_BLOCKS),
		.DW    (LW),
		.AW    (AW)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// one step of the allocate walk: ram_rdata is the link of the head block
	assign got_n    = got_q + CNT_W'(1);
	assign nh_empty = (ram_rdata >= LIST_END);
	assign walk_end = (got_n == want_q) || nh_empty;
	assign out_sum  = {1'b0, out_q} + {1'b0, got_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cfg_q    <= CFG_RESET;
			head_q   <= LIST_END;
			out_q    <= '0;
			init_q   <= '0;
			want_q   <= '0;
			got_q    <= '0;
			strobe_q <= 1'b0;
			blk_q    <= '0;
			valid_q  <= 1'b0;
			cnt_q    <= '0;
			empty_q  <= 1'b0;
			status_q <= FST_OK;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= blocks_in_page;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						blk_q    <= '0;
						valid_q  <= 1'b0;
						cnt_q    <= '0;
						empty_q  <= 1'b0;
						status_q <= FST_OK;
						last_q   <= 1'b1;
						case (rtype)
							REQ_INIT: begin
								init_q  <= '0;
								head_q  <= '0;
								out_q   <= '0;
								state_q <= ST_INIT;
							end
							REQ_ALLOC: begin
								if (want_c == '0 || head_empty) begin
									strobe_q <= 1'b1;
									empty_q  <= head_empty;
								end else begin
									want_q  <= want_c;
									got_q   <= '0;
									state_q <= ST_ALLOC_WB;
								end
							end
							default: begin
								strobe_q <= 1'b1;
								status_q <= fdec.status;
								if (fdec.push) begin
									head_q <= LW'(block_index);
									out_q  <= out_q - CNT_W'(1);
								end
							end
						endcase
					end
				end
				ST_INIT: begin
					init_q <= init_nxt;
					if (init_nxt == n_eff) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_ALLOC_RD: begin
					state_q <= ST_ALLOC_WB;
				end
				ST_ALLOC_WB: begin
					strobe_q <= 1'b1;
					blk_q    <= IDX_W'(head_q);
					valid_q  <= 1'b1;
					status_q <= FST_OK;
					head_q   <= ram_rdata;
					got_q    <= got_n;
					if (walk_end) begin
						cnt_q   <= got_n;
						empty_q <= nh_empty;
						last_q  <= 1'b1;
						out_q   <= (out_sum > {1'b0, OUT_LIMIT}) ? OUT_LIMIT
							: out_sum[CNT_W-1:0];
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= '0;
						empty_q <= 1'b0;
						last_q  <= 1'b0;
						state_q <= ST_ALLOC_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign alloc_block   = blk_q;
	assign block_valid   = valid_q;
	assign alloc_count   = cnt_q;
	assign now_empty     = empty_q;
	assign free_status   = status_q;
	assign last          = last_q;

endmodule
